// ===== hdl/bupr_pkg.sv =====
// shared constants, types and controller states for the bright unlabeled pixel replacer
package bupr_pkg;

  localparam int PIX_W      = 16;
  localparam int COUNT_BITS = 24;
  localparam int SUM_BITS   = COUNT_BITS + PIX_W - 1;
  localparam int QUO_BITS   = PIX_W;
  localparam int STEP_W     = $clog2(QUO_BITS);

  localparam logic MODE_GATHER  = 1'b0;
  localparam logic MODE_CORRECT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_EMIT
  } bupr_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic gather;
    logic calc;
    logic div_start;
    logic div_step;
    logic emit;
  } bupr_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic mode;
    logic dirty;
    logic div_last;
    logic out_free;
  } bupr_sts_t;

endpackage

// ===== hdl/bupr_ctrl.sv =====
// controller state machine sequencing capture, gather, division and result
module bupr_ctrl import bupr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bupr_sts_t sts,
  output bupr_cmd_t cmd
);

  bupr_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.mode == MODE_GATHER) state_nxt = ST_IDLE;
        else if (sts.dirty)          state_nxt = ST_DIV;
        else                         state_nxt = ST_EMIT;
      end
      ST_DIV: begin
        if (sts.div_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        cmd.gather    = (sts.mode == MODE_GATHER);
        cmd.calc      = (sts.mode == MODE_CORRECT);
        cmd.div_start = (sts.mode == MODE_CORRECT) && sts.dirty;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== hdl/bupr_dp.sv =====
// datapath: accumulators, fill divider, brightness compare and output register
module bupr_dp import bupr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic signed [PIX_W-1:0] cfg_wdata,
  input  logic                    in_mode,
  input  logic                    in_first_of_pass,
  input  logic signed [PIX_W-1:0] in_pixel,
  input  logic signed [PIX_W-1:0] in_label,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [PIX_W-1:0] out_pixel_out,
  output logic                    out_was_replaced,
  input  bupr_cmd_t               cmd,
  output bupr_sts_t               sts
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic signed [PIX_W-1:0]  wm_label_r;
  logic                     mode_r, first_r;
  logic signed [PIX_W-1:0]  pix_r, lab_r;
  logic [SUM_BITS-1:0]      wm_sum_r, lab_sum_r;
  logic [COUNT_BITS-1:0]    wm_cnt_r, lab_cnt_r;
  logic [SUM_BITS-1:0]      wm_sum_nxt, lab_sum_nxt;
  logic [COUNT_BITS-1:0]    wm_cnt_nxt, lab_cnt_nxt;
  logic                     dirty_r;
  logic [PIX_W-1:0]         fill_r;
  logic [SUM_BITS-1:0]      rem_r, dsh_r, rem_nxt;
  logic [QUO_BITS-1:0]      quo_r, quo_nxt;
  logic [STEP_W-1:0]        step_r;
  logic                     den_zero_r;
  logic                     qbit;
  logic [SUM_BITS-1:0]      prod_r;
  logic                     out_valid_r, out_repl_r;
  logic signed [PIX_W-1:0]  out_pix_r;
  logic                     pix_pos, wm_hit, lab_hit, replace;
  logic [SUM_BITS-1:0]      wm_sum_base, lab_sum_base, pix_ext;
  logic [COUNT_BITS-1:0]    wm_cnt_base, lab_cnt_base;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm_label_r <= '0;
    end else if (cfg_we) begin
      wm_label_r <= cfg_wdata;
    end
  end

  // item capture at input transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      first_r <= in_first_of_pass;
      pix_r   <= in_pixel;
      lab_r   <= in_label;
    end
  end

  // gather: restart from zero on the first pixel of a pass, add qualifying positive pixels
  always_comb begin
    pix_pos      = (pix_r > 0);
    wm_hit       = pix_pos && (lab_r == wm_label_r);
    lab_hit      = pix_pos && (lab_r != '0);
    pix_ext      = SUM_BITS'(unsigned'(pix_r[PIX_W-2:0]));
    wm_sum_base  = first_r ? '0 : wm_sum_r;
    wm_cnt_base  = first_r ? '0 : wm_cnt_r;
    lab_sum_base = first_r ? '0 : lab_sum_r;
    lab_cnt_base = first_r ? '0 : lab_cnt_r;
    wm_sum_nxt   = wm_sum_base;
    wm_cnt_nxt   = wm_cnt_base;
    lab_sum_nxt  = lab_sum_base;
    lab_cnt_nxt  = lab_cnt_base;
    if (wm_hit && (wm_cnt_base != COUNT_MAX)) begin
      wm_sum_nxt = wm_sum_base + pix_ext;
      wm_cnt_nxt = wm_cnt_base + 1'b1;
    end
    if (lab_hit && (lab_cnt_base != COUNT_MAX)) begin
      lab_sum_nxt = lab_sum_base + pix_ext;
      lab_cnt_nxt = lab_cnt_base + 1'b1;
    end
  end

  // accumulators and fill staleness flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm_sum_r  <= '0;
      wm_cnt_r  <= '0;
      lab_sum_r <= '0;
      lab_cnt_r <= '0;
      dirty_r   <= 1'b1;
    end else if (cmd.gather) begin
      wm_sum_r  <= wm_sum_nxt;
      wm_cnt_r  <= wm_cnt_nxt;
      lab_sum_r <= lab_sum_nxt;
      lab_cnt_r <= lab_cnt_nxt;
      dirty_r   <= 1'b1;
    end else if (cmd.div_step && (step_r == '0)) begin
      dirty_r   <= 1'b0;
    end
  end

  // restoring division step, one quotient bit a cycle
  always_comb begin
    qbit    = (rem_r >= dsh_r);
    rem_nxt = qbit ? (rem_r - dsh_r) : rem_r;
    quo_nxt = {quo_r[QUO_BITS-2:0], qbit};
  end

  // fill divider: labeled mean stays below 2^15, so 16 quotient bits suffice
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r      <= lab_sum_r;
      dsh_r      <= {lab_cnt_r, {(QUO_BITS-1){1'b0}}};
      quo_r      <= '0;
      step_r     <= STEP_W'(QUO_BITS-1);
      den_zero_r <= (lab_cnt_r == '0);
    end else if (cmd.div_step) begin
      rem_r  <= rem_nxt;
      dsh_r  <= dsh_r >> 1;
      quo_r  <= quo_nxt;
      step_r <= step_r - 1'b1;
    end
  end

  // fill value register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.div_step && (step_r == '0)) begin
      fill_r <= den_zero_r ? '0 : quo_nxt;
    end
  end

  // pixel times white-matter count, for the exact mean compare
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      prod_r <= SUM_BITS'(unsigned'(pix_r[PIX_W-2:0])) * SUM_BITS'(wm_cnt_r);
    end
  end

  assign replace = (wm_cnt_r != '0) && (lab_r == '0) && (pix_r > 0) && (prod_r > wm_sum_r);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pix_r  <= replace ? signed'(fill_r) : pix_r;
      out_repl_r <= replace;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_out    = out_pix_r;
  assign out_was_replaced = out_repl_r;

  // status to the controller
  always_comb begin
    sts.mode     = mode_r;
    sts.dirty    = dirty_r;
    sts.div_last = (step_r == '0);
    sts.out_free = !out_valid_r || out_ready;
  end

endmodule

// ===== hdl/bright_unlabeled_pixel_replacer.sv =====
// top level: replaces bright unlabeled pixels with the labeled mean
// gather pixel: captured, then accumulated in ST_EXEC, gives no result
// correct pixel: result registered in ST_EMIT when output is free, then ST_IDLE
// the first correct pixel after reset or after any gather pixel also runs the
// fill division in ST_DIV (one quotient bit per cycle in the divider)
// synchronous active-low reset clears accumulators, fill value and wm_label to zero
module bright_unlabeled_pixel_replacer import bupr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic signed [PIX_W-1:0] cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_mode,
  input  logic                    in_first_of_pass,
  input  logic signed [PIX_W-1:0] in_pixel,
  input  logic signed [PIX_W-1:0] in_label,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [PIX_W-1:0] out_pixel_out,
  output logic                    out_was_replaced
);

  bupr_cmd_t cmd;
  bupr_sts_t sts;

  // controller
  bupr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  bupr_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_mode          (in_mode),
    .in_first_of_pass (in_first_of_pass),
    .in_pixel         (in_pixel),
    .in_label         (in_label),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_out    (out_pixel_out),
    .out_was_replaced (out_was_replaced),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule
